// File: hdl/tgi_pkg.sv
// Package for the trilinear grid interpolator.
// Holds the fixed field widths, parameter defaults and item kind codes.
// No dependencies.
package tgi_pkg;

  localparam int MaxGridDef  = 16;
  localparam int FracBitsDef = 16;

  localparam int ValW  = 32;
  localparam int PosW  = 18;
  localparam int IdxW  = 12;
  localparam int GridW = 5;

  localparam logic [GridW-1:0] GridReset = 5'd16;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

endpackage

// File: hdl/tgi_blend.sv
// Two-stage linear blend a + floor(((b - a) * w) / 2^FRAC_BITS).
// Depends on tgi_pkg for the value width.
module tgi_blend import tgi_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [ValW-1:0] b_i,
  input  logic [FRAC_BITS:0]     w_i,
  output logic signed [ValW-1:0] y_o
);

  localparam int DiffW = ValW + 1;
  localparam int ProdW = DiffW + FRAC_BITS + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ValW-1:0]  a_q, y_q;
  logic signed [ProdW-1:0] shifted;
  logic signed [DiffW-1:0] sum;

  assign diff   = DiffW'(b_i) - DiffW'(a_i);
  assign prod_d = ProdW'(diff) * ProdW'($signed({1'b0, w_i}));

  // The blend stays between its operands, so the sum fits the value width.
  assign shifted = prod_q >>> FRAC_BITS;
  assign sum     = DiffW'(a_q) + DiffW'(shifted);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_i;
      prod_q <= prod_d;
      y_q    <= ValW'(sum);
    end
  end

  assign y_o = y_q;

endmodule

// File: hdl/trilinear_grid_interpolator.sv
// Top level of the trilinear grid interpolator.
// Depends on tgi_pkg and tgi_blend.
//
// Usage: a request on the input channel is either a node write (kind 0) or a
// query (kind 1). A write stores node_value at the flat z-major node_index and
// gives no result; a query gives one interp_value on the output channel.
// The configuration channel sets grid_points, the nodes per axis, and is
// always ready; write it only while the block is idle.
// Throughput: one request per cycle unless the receiver stalls. The 12
// pipeline stages are the axis scaling multiply, floor and clamp, two index
// multiply stages, corner address adds, the store read, and three two-stage
// blends (x, y, z).
// The store is held in four copies with two read ports each, so all eight
// corners are read in the same cycle; every write goes to all copies.
// When the receiver stalls, the whole pipeline holds and input ready drops;
// nothing is lost or repeated. Reset clears the pipeline valid bits and sets
// grid_points to 16. Node values are undefined until written.
module trilinear_grid_interpolator import tgi_pkg::*; #(
  parameter int MAX_GRID  = MaxGridDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [GridW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [IdxW-1:0]         node_index_i,
  input  logic signed [ValW-1:0]  node_value_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic signed [PosW-1:0]  pos_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ValW-1:0]  interp_value_o
);

  localparam int StoreDepth = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(StoreDepth);
  localparam int CW    = $clog2(MAX_GRID);
  localparam int GW    = $clog2(MAX_GRID + 1);
  localparam int GxW   = PosW + GW + 1;
  localparam int DW    = ((GxW > CW + FRAC_BITS + 1) ? GxW : (CW + FRAC_BITS + 1)) + 1;
  localparam int ZW    = CW + GW + 1;
  localparam int IW    = ZW + GW;
  localparam int NStg  = 12;
  localparam int WOne  = 1 << FRAC_BITS;

  typedef struct packed {
    logic [FRAC_BITS:0] wx;
    logic [FRAC_BITS:0] wy;
    logic [FRAC_BITS:0] wz;
  } wts_t;

  logic                advance;
  logic [GridW-1:0]    grid_q;
  logic [NStg-1:0]     vld_d, vld_q;
  logic [GW-1:0]       g_now;

  // Payload that travels through stages 1 to 5.
  logic                kind_q   [1:5];
  logic [IdxW-1:0]     nidx_q   [1:5];
  logic signed [ValW-1:0] nval_q [1:5];
  logic [GW-1:0]       g_q      [1:4];

  logic signed [GxW-1:0] gx_d [3];
  logic signed [GxW-1:0] gx_q [3];
  logic [CW-1:0]         base_d [3];
  logic [CW-1:0]         base_q [3];
  wts_t                  wts_d;
  wts_t                  wt_q [2:10];
  logic [ZW-1:0]         zg_q;
  logic [CW-1:0]         i3_q;
  logic [2*GW-1:0]       gg3_q;
  logic [AW-1:0]         idx_q, gg4_q;
  logic [GW-1:0]         gm1, gm2;
  logic [AW-1:0]         addr_d [8];
  logic [AW-1:0]         addr_q [8];
  logic signed [ValW-1:0] rd_q [8];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [ValW-1:0] cx [4];
  logic signed [ValW-1:0] cy [2];

  assign advance     = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = advance;
  assign out_valid_o = vld_q[NStg-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GridReset;
    end else if (cfg_valid_i) begin
      grid_q <= cfg_data_i;
    end
  end

  // Writes produce no result, so their valid bit is dropped after the store.
  assign vld_d = {vld_q[NStg-2:5], vld_q[4] && (kind_q[5] == KindQuery),
                  vld_q[3:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    if (grid_q < GridW'(2)) begin
      g_now = GW'(2);
    end else if (32'(grid_q) > 32'(MAX_GRID)) begin
      g_now = GW'(MAX_GRID);
    end else begin
      g_now = GW'(grid_q);
    end
  end

  assign gm1 = g_now - GW'(1);
  assign gx_d[0] = GxW'(pos_x_i) * GxW'($signed({1'b0, gm1}));
  assign gx_d[1] = GxW'(pos_y_i) * GxW'($signed({1'b0, gm1}));
  assign gx_d[2] = GxW'(pos_z_i) * GxW'($signed({1'b0, gm1}));

  // Floor to a cell index, clamp it to 0..g-2, and clamp the fraction to 0..1.
  assign gm2 = g_q[1] - GW'(2);
  always_comb begin
    logic signed [GxW-1:0] braw;
    logic signed [DW-1:0]  wd;
    logic [FRAC_BITS:0]    wsel [3];
    for (int a = 0; a < 3; a++) begin
      braw = gx_q[a] >>> FRAC_BITS;
      if (braw < 0) begin
        base_d[a] = '0;
      end else if (braw > GxW'($signed({1'b0, gm2}))) begin
        base_d[a] = CW'(gm2);
      end else begin
        base_d[a] = CW'(braw);
      end
      wd = DW'(gx_q[a]) - ($signed(DW'(base_d[a])) <<< FRAC_BITS);
      if (wd < 0) begin
        wsel[a] = '0;
      end else if (wd > $signed(DW'(WOne))) begin
        wsel[a] = (FRAC_BITS + 1)'(WOne);
      end else begin
        wsel[a] = (FRAC_BITS + 1)'(wd);
      end
    end
    wts_d.wx = wsel[0];
    wts_d.wy = wsel[1];
    wts_d.wz = wsel[2];
  end

  always_comb begin
    addr_d[0] = idx_q;
    addr_d[1] = idx_q + AW'(1);
    addr_d[2] = idx_q + AW'(g_q[4]);
    addr_d[3] = idx_q + AW'(g_q[4]) + AW'(1);
    addr_d[4] = idx_q + gg4_q;
    addr_d[5] = idx_q + gg4_q + AW'(1);
    addr_d[6] = idx_q + gg4_q + AW'(g_q[4]);
    addr_d[7] = idx_q + gg4_q + AW'(g_q[4]) + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q[1] <= kind_i;
      nidx_q[1] <= node_index_i;
      nval_q[1] <= node_value_i;
      g_q[1]    <= g_now;
      for (int a = 0; a < 3; a++) begin
        gx_q[a]   <= gx_d[a];
        base_q[a] <= base_d[a];
      end
      for (int s = 2; s <= 5; s++) begin
        kind_q[s] <= kind_q[s-1];
        nidx_q[s] <= nidx_q[s-1];
        nval_q[s] <= nval_q[s-1];
      end
      for (int s = 2; s <= 4; s++) begin
        g_q[s] <= g_q[s-1];
      end
      wt_q[2] <= wts_d;
      for (int s = 3; s <= 10; s++) begin
        wt_q[s] <= wt_q[s-1];
      end
      zg_q  <= ZW'(base_q[2]) * ZW'(g_q[2]) + ZW'(base_q[1]);
      i3_q  <= base_q[0];
      gg3_q <= (2 * GW)'(g_q[2]) * (2 * GW)'(g_q[2]);
      idx_q <= AW'(IW'(zg_q) * IW'(g_q[3]) + IW'(i3_q));
      gg4_q <= AW'(gg3_q);
      for (int c = 0; c < 8; c++) begin
        addr_q[c] <= addr_d[c];
      end
    end
  end

  assign mem_we    = advance && vld_q[4] && (kind_q[5] == KindWrite) &&
                     (32'(nidx_q[5]) < 32'(StoreDepth));
  assign mem_waddr = AW'(nidx_q[5]);

  for (genvar c = 0; c < 4; c++) begin : g_copy
    logic signed [ValW-1:0] mem [StoreDepth];
    always_ff @(posedge clk_i) begin
      if (mem_we) begin
        mem[mem_waddr] <= nval_q[5];
      end
      if (advance) begin
        rd_q[2*c]   <= mem[addr_q[2*c]];
        rd_q[2*c+1] <= mem[addr_q[2*c+1]];
      end
    end
  end

  // Corner pairs along x: (y0,z0), (y1,z0), (y0,z1), (y1,z1).
  for (genvar p = 0; p < 4; p++) begin : g_bx
    tgi_blend #(.FRAC_BITS(FRAC_BITS)) u_bx (
      .clk_i (clk_i),
      .en_i  (advance),
      .a_i   (rd_q[2*p]),
      .b_i   (rd_q[2*p+1]),
      .w_i   (wt_q[6].wx),
      .y_o   (cx[p])
    );
  end

  for (genvar p = 0; p < 2; p++) begin : g_by
    tgi_blend #(.FRAC_BITS(FRAC_BITS)) u_by (
      .clk_i (clk_i),
      .en_i  (advance),
      .a_i   (cx[2*p]),
      .b_i   (cx[2*p+1]),
      .w_i   (wt_q[8].wy),
      .y_o   (cy[p])
    );
  end

  tgi_blend #(.FRAC_BITS(FRAC_BITS)) u_bz (
    .clk_i (clk_i),
    .en_i  (advance),
    .a_i   (cy[0]),
    .b_i   (cy[1]),
    .w_i   (wt_q[10].wz),
    .y_o   (interp_value_o)
  );

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && vld_q[4] && (kind_q[5] == KindWrite) |=> !vld_q[5])
    else $error("a node write went on toward the output");

  a_base_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (32'(base_d[0]) <= 32'(g_q[1]) - 2) &&
                 (32'(base_d[2]) <= 32'(g_q[1]) - 2))
    else $error("cell index outside the grid");

  a_weight_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (32'(wts_d.wx) <= WOne) && (32'(wts_d.wy) <= WOne) &&
                 (32'(wts_d.wz) <= WOne))
    else $error("weight above one");

endmodule
